// ===== rtl/core/sewbc_pkg.sv =====
// Package for the SPI EEPROM write-back cache sequencer.
// Holds the function codes, SPI command bytes, phase type and the control structs.
// Depends on nothing.
`default_nettype none

package sewbc_pkg;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_READ  = 2'd1,
        FN_LOAD  = 2'd2,
        FN_BYTE  = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_ENABLE     = 4'd1,
        PH_CMD        = 4'd2,
        PH_ADDRESS    = 4'd3,
        PH_DATA       = 4'd4,
        PH_STATUS1    = 4'd5,
        PH_STATUS2    = 4'd6,
        PH_DISABLE    = 4'd7,
        PH_RD_START   = 4'd8,
        PH_RD_ADDRESS = 4'd9,
        PH_RD_DATA    = 4'd10
    } t_phase;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } t_cstate;

    typedef enum logic [3:0] {
        TX_NONE  = 4'd0,
        TX_WREN  = 4'd1,
        TX_WRITE = 4'd2,
        TX_RDSR  = 4'd3,
        TX_WRDI  = 4'd4,
        TX_READ  = 4'd5,
        TX_ADDR  = 4'd6,
        TX_DATA  = 4'd7,
        TX_ZERO  = 4'd8
    } t_tx_sel;

    localparam logic [7:0] CMD_WREN       = 8'h06;
    localparam logic [7:0] CMD_WRITE      = 8'h02;
    localparam logic [7:0] CMD_RD_STATUS  = 8'h05;
    localparam logic [7:0] CMD_WR_DISABLE = 8'h04;
    localparam logic [7:0] CMD_READ       = 8'h03;
    localparam int         WIP_BIT        = 0;

    typedef struct packed {
        logic    latch;
        logic    exec;
        logic    cache_wr_host;
        logic    load_wr;
        logic    clr_load;
        logic    push;
        logic    pop;
        logic    set_cur;
        logic    rd_en;
        logic    tx_valid;
        t_tx_sel tx_sel;
        logic    cs_pulse;
        logic    load_done;
        logic    overflow;
        logic    res_idle;
    } t_ctrl_cmd;

    typedef struct packed {
        t_func func;
        logic  addr_ok;
        logic  q_empty;
        logic  q_full;
        logic  load_last;
        logic  wip;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/sewbc_dp.sv =====
// Datapath of the SPI EEPROM write-back cache sequencer.
// Holds the byte cache with valid bits, the address ring, counters and result registers.
// Depends on sewbc_pkg.
`default_nettype none

module sewbc_dp #(
    parameter int QUEUE_DEPTH = 32,
    parameter int CACHE_BYTES = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [1:0]            i_func,
    input  wire logic [7:0]            i_addr,
    input  wire logic [7:0]            i_wr_data,
    input  wire logic [7:0]            i_rx_byte,
    input  wire sewbc_pkg::t_ctrl_cmd  i_cmd,
    output sewbc_pkg::t_dp_status      o_status,
    output logic                       o_tx_valid,
    output logic [7:0]                 o_tx_byte,
    output logic                       o_cs_pulse,
    output logic                       o_cs_high,
    output logic [7:0]                 o_rd_data,
    output logic                       o_load_done,
    output logic                       o_busy_res,
    output logic                       o_overflow
);

    localparam int CW = (CACHE_BYTES > 1) ? $clog2(CACHE_BYTES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LW = $clog2(CACHE_BYTES + 1);

    logic [7:0]             r_cache [CACHE_BYTES];
    logic [7:0]             r_queue [QUEUE_DEPTH];
    logic [CACHE_BYTES-1:0] r_valid;

    logic [1:0]    r_func;
    logic [7:0]    r_addr;
    logic [7:0]    r_wr_data;
    logic [7:0]    r_rx_byte;
    logic [7:0]    r_cache_q;
    logic          r_valid_q;
    logic [7:0]    r_queue_q;
    logic [7:0]    r_cur;
    logic [QW-1:0] r_head;
    logic [QW-1:0] r_tail;
    logic [LW-1:0] r_load_cnt;

    logic [QW-1:0] n_head;
    logic [QW-1:0] n_tail;
    logic [CW-1:0] n_rd_idx;
    logic [CW-1:0] n_wr_idx;
    logic [7:0]    n_wr_val;
    logic          n_wr_en;
    logic [7:0]    n_tx_byte;
    logic [7:0]    n_cache_byte;

    function automatic logic [QW-1:0] ring_next(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        n_head       = ring_next(r_head);
        n_tail       = ring_next(r_tail);
        n_rd_idx     = (i_func == sewbc_pkg::FN_READ) ? i_addr[CW-1:0] : r_cur[CW-1:0];
        n_wr_en      = i_cmd.cache_wr_host || i_cmd.load_wr;
        n_wr_idx     = i_cmd.load_wr ? r_load_cnt[CW-1:0] : r_addr[CW-1:0];
        n_wr_val     = i_cmd.load_wr ? r_rx_byte : r_wr_data;
        n_cache_byte = r_valid_q ? r_cache_q : 8'h00;
        case (i_cmd.tx_sel)
            sewbc_pkg::TX_WREN:  n_tx_byte = sewbc_pkg::CMD_WREN;
            sewbc_pkg::TX_WRITE: n_tx_byte = sewbc_pkg::CMD_WRITE;
            sewbc_pkg::TX_RDSR:  n_tx_byte = sewbc_pkg::CMD_RD_STATUS;
            sewbc_pkg::TX_WRDI:  n_tx_byte = sewbc_pkg::CMD_WR_DISABLE;
            sewbc_pkg::TX_READ:  n_tx_byte = sewbc_pkg::CMD_READ;
            sewbc_pkg::TX_ADDR:  n_tx_byte = r_cur;
            sewbc_pkg::TX_DATA:  n_tx_byte = n_cache_byte;
            default:             n_tx_byte = 8'h00;
        endcase
    end

    assign o_status.func      = sewbc_pkg::t_func'(r_func);
    assign o_status.addr_ok   = ({1'b0, r_addr} < 9'(CACHE_BYTES));
    assign o_status.q_empty   = (r_head == r_tail);
    assign o_status.q_full    = (n_head == r_tail);
    assign o_status.load_last = (r_load_cnt == LW'(CACHE_BYTES - 1));
    assign o_status.wip       = r_rx_byte[sewbc_pkg::WIP_BIT];

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_cache[n_wr_idx] <= n_wr_val;
        end
        if (i_cmd.latch) begin
            r_cache_q <= r_cache[n_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_queue[n_head] <= r_addr;
        end
        if (i_cmd.latch) begin
            r_queue_q <= r_queue[n_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func    <= i_func;
            r_addr    <= i_addr;
            r_wr_data <= i_wr_data;
            r_rx_byte <= i_rx_byte;
            r_valid_q <= r_valid[n_rd_idx];
        end
        if (i_cmd.exec) begin
            o_tx_valid  <= i_cmd.tx_valid;
            o_tx_byte   <= n_tx_byte;
            o_cs_pulse  <= i_cmd.cs_pulse;
            o_cs_high   <= i_cmd.res_idle;
            o_busy_res  <= !i_cmd.res_idle;
            o_load_done <= i_cmd.load_done;
            o_overflow  <= i_cmd.overflow;
            o_rd_data   <= (i_cmd.rd_en && o_status.addr_ok) ? n_cache_byte : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_cur      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_load_cnt <= '0;
        end else begin
            if (n_wr_en) begin
                r_valid[n_wr_idx] <= 1'b1;
            end
            if (i_cmd.set_cur) begin
                r_cur <= r_addr;
            end else if (i_cmd.pop) begin
                r_cur <= r_queue_q;
            end
            if (i_cmd.push) begin
                r_head <= n_head;
            end
            if (i_cmd.pop) begin
                r_tail <= n_tail;
            end
            if (i_cmd.clr_load) begin
                r_load_cnt <= '0;
            end else if (i_cmd.load_wr) begin
                r_load_cnt <= r_load_cnt + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sewbc_ctrl.sv =====
// Controller of the SPI EEPROM write-back cache sequencer.
// Holds the handshake state, the SPI phase machine and the result strobe.
// Depends on sewbc_pkg.
`default_nettype none

module sewbc_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    input  wire sewbc_pkg::t_dp_status i_status,
    output sewbc_pkg::t_ctrl_cmd       o_cmd,
    output logic                       busy,
    output logic                       o_strobe
);

    sewbc_pkg::t_cstate r_state;
    sewbc_pkg::t_cstate n_state;
    sewbc_pkg::t_phase  r_phase;
    sewbc_pkg::t_phase  n_phase;
    logic               r_strobe;
    logic               n_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sewbc_pkg::CS_IDLE;
            r_phase  <= sewbc_pkg::PH_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_strobe <= n_strobe;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_strobe = 1'b0;
        o_cmd    = '0;
        case (r_state)
            sewbc_pkg::CS_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = sewbc_pkg::CS_EXEC;
                end
            end
            sewbc_pkg::CS_EXEC: begin
                o_cmd.exec = 1'b1;
                n_strobe   = 1'b1;
                n_state    = sewbc_pkg::CS_IDLE;
                case (i_status.func)
                    sewbc_pkg::FN_WRITE: begin
                        if (i_status.addr_ok) begin
                            o_cmd.cache_wr_host = 1'b1;
                            if (r_phase == sewbc_pkg::PH_IDLE) begin
                                o_cmd.set_cur  = 1'b1;
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_WREN;
                                n_phase        = sewbc_pkg::PH_ENABLE;
                            end else if (i_status.q_full) begin
                                o_cmd.overflow = 1'b1;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                    end
                    sewbc_pkg::FN_READ: begin
                        o_cmd.rd_en = 1'b1;
                    end
                    sewbc_pkg::FN_LOAD: begin
                        if (r_phase == sewbc_pkg::PH_IDLE) begin
                            o_cmd.clr_load = 1'b1;
                            o_cmd.tx_valid = 1'b1;
                            o_cmd.tx_sel   = sewbc_pkg::TX_READ;
                            n_phase        = sewbc_pkg::PH_RD_START;
                        end
                    end
                    default: begin
                        case (r_phase)
                            sewbc_pkg::PH_IDLE: begin
                                n_phase = sewbc_pkg::PH_IDLE;
                            end
                            sewbc_pkg::PH_ENABLE: begin
                                o_cmd.cs_pulse = 1'b1;
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_WRITE;
                                n_phase        = sewbc_pkg::PH_CMD;
                            end
                            sewbc_pkg::PH_CMD: begin
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_ADDR;
                                n_phase        = sewbc_pkg::PH_ADDRESS;
                            end
                            sewbc_pkg::PH_ADDRESS: begin
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_DATA;
                                n_phase        = sewbc_pkg::PH_DATA;
                            end
                            sewbc_pkg::PH_DATA: begin
                                o_cmd.cs_pulse = 1'b1;
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_RDSR;
                                n_phase        = sewbc_pkg::PH_STATUS1;
                            end
                            sewbc_pkg::PH_STATUS1: begin
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_ZERO;
                                n_phase        = sewbc_pkg::PH_STATUS2;
                            end
                            sewbc_pkg::PH_STATUS2: begin
                                o_cmd.cs_pulse = 1'b1;
                                o_cmd.tx_valid = 1'b1;
                                if (i_status.wip) begin
                                    o_cmd.tx_sel = sewbc_pkg::TX_RDSR;
                                    n_phase      = sewbc_pkg::PH_STATUS1;
                                end else begin
                                    o_cmd.tx_sel = sewbc_pkg::TX_WRDI;
                                    n_phase      = sewbc_pkg::PH_DISABLE;
                                end
                            end
                            sewbc_pkg::PH_DISABLE: begin
                                if (i_status.q_empty) begin
                                    n_phase = sewbc_pkg::PH_IDLE;
                                end else begin
                                    o_cmd.pop      = 1'b1;
                                    o_cmd.cs_pulse = 1'b1;
                                    o_cmd.tx_valid = 1'b1;
                                    o_cmd.tx_sel   = sewbc_pkg::TX_WREN;
                                    n_phase        = sewbc_pkg::PH_ENABLE;
                                end
                            end
                            sewbc_pkg::PH_RD_START: begin
                                o_cmd.clr_load = 1'b1;
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_ZERO;
                                n_phase        = sewbc_pkg::PH_RD_ADDRESS;
                            end
                            sewbc_pkg::PH_RD_ADDRESS: begin
                                o_cmd.tx_valid = 1'b1;
                                o_cmd.tx_sel   = sewbc_pkg::TX_ZERO;
                                n_phase        = sewbc_pkg::PH_RD_DATA;
                            end
                            sewbc_pkg::PH_RD_DATA: begin
                                o_cmd.load_wr = 1'b1;
                                if (i_status.load_last) begin
                                    o_cmd.load_done = 1'b1;
                                    n_phase         = sewbc_pkg::PH_IDLE;
                                end else begin
                                    o_cmd.tx_valid = 1'b1;
                                    o_cmd.tx_sel   = sewbc_pkg::TX_ZERO;
                                end
                            end
                            default: begin
                                n_phase = sewbc_pkg::PH_IDLE;
                            end
                        endcase
                    end
                endcase
                o_cmd.res_idle = (n_phase == sewbc_pkg::PH_IDLE);
            end
            default: begin
                n_state = sewbc_pkg::CS_IDLE;
            end
        endcase
    end

    assign busy     = (r_state == sewbc_pkg::CS_EXEC);
    assign o_strobe = r_strobe;

endmodule

`default_nettype wire

// ===== rtl/core/spi_eeprom_write_back_cache.sv =====
// Top level of the SPI EEPROM write-back cache sequencer.
// Joins the controller and the datapath; depends on sewbc_pkg, sewbc_ctrl and sewbc_dp.
// For each beat, the edge that accepts it (start high, busy low) also registers the
// cache and queue read data, busy is high for the one execute cycle after it, and
// the result is on the ports for the following cycle with o_strobe high. The next
// start is taken in that strobe cycle, so a new beat can be accepted while the
// previous result is still on the ports. The result cannot be held off and must be
// taken when o_strobe is high. Reset clears the cache valid bits at once, so no
// clearing pass follows it.
`default_nettype none

module spi_eeprom_write_back_cache #(
    parameter int QUEUE_DEPTH = 32,
    parameter int CACHE_BYTES = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_func,
    input  wire logic [7:0] i_addr,
    input  wire logic [7:0] i_wr_data,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_strobe,
    output logic            o_tx_valid,
    output logic [7:0]      o_tx_byte,
    output logic            o_cs_pulse,
    output logic            o_cs_high,
    output logic [7:0]      o_rd_data,
    output logic            o_load_done,
    output logic            o_busy_res,
    output logic            o_overflow
);

    sewbc_pkg::t_ctrl_cmd  w_cmd;
    sewbc_pkg::t_dp_status w_status;

    sewbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    sewbc_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CACHE_BYTES (CACHE_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_func),
        .i_addr      (i_addr),
        .i_wr_data   (i_wr_data),
        .i_rx_byte   (i_rx_byte),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_cs_pulse  (o_cs_pulse),
        .o_cs_high   (o_cs_high),
        .o_rd_data   (o_rd_data),
        .o_load_done (o_load_done),
        .o_busy_res  (o_busy_res),
        .o_overflow  (o_overflow)
    );

endmodule

`default_nettype wire

// ===== rtl/core/sewbc_checker.sv =====
// Port-level checker for the SPI EEPROM write-back cache sequencer.
// Watches only the top-level ports and is bound to spi_eeprom_write_back_cache.
`default_nettype none

module sewbc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic       o_tx_valid,
    input wire logic [7:0] o_tx_byte,
    input wire logic       o_cs_high,
    input wire logic       o_busy_res
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("execute cycle was not followed by a result strobe");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_cs_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cs_high != o_busy_res))
        else $error("chip select level disagrees with sequencer busy");

    a_tx_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_tx_valid) |-> (o_tx_byte == 8'h00))
        else $error("transmit byte not zero when nothing is sent");

endmodule

bind spi_eeprom_write_back_cache sewbc_checker u_sewbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_strobe   (o_strobe),
    .o_tx_valid (o_tx_valid),
    .o_tx_byte  (o_tx_byte),
    .o_cs_high  (o_cs_high),
    .o_busy_res (o_busy_res)
);

`default_nettype wire

// ===== sim/spi_eeprom_write_back_cache_tb.sv =====
// Self-checking testbench for the SPI EEPROM write-back cache sequencer.
// A scoreboard class predicts every result beat from the accepted commands and checks it.
// Depends on sewbc_pkg and spi_eeprom_write_back_cache.
`timescale 1ns / 100ps

module spi_eeprom_write_back_cache_tb;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_pulse;
        logic       cs_high;
        logic [7:0] rd_data;
        logic       load_done;
        logic       busy_res;
        logic       overflow;
    } t_spi_beat;

    class t_beat_scoreboard;
        localparam int QUEUE_DEPTH = 32;
        localparam int CACHE_BYTES = 256;

        sewbc_pkg::t_phase phase;
        logic [7:0]        cur_addr;
        logic [7:0]        pending_addr [QUEUE_DEPTH];
        logic [4:0]        q_head;
        logic [4:0]        q_tail;
        logic [7:0]        cache [CACHE_BYTES];
        logic [8:0]        load_cnt;
        t_spi_beat         expected_beats [$];
        int                errors;
        int                beat_no;

        function new();
            phase    = sewbc_pkg::PH_IDLE;
            cur_addr = '0;
            q_head   = '0;
            q_tail   = '0;
            load_cnt = '0;
            errors   = 0;
            beat_no  = 0;
            foreach (cache[i]) cache[i] = '0;
            foreach (pending_addr[i]) pending_addr[i] = '0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function logic [4:0] ring_next(logic [4:0] p);
            return (int'(p) + 1 >= QUEUE_DEPTH) ? 5'd0 : p + 5'd1;
        endfunction

        function void note_command(sewbc_pkg::t_func f, logic [7:0] a, logic [7:0] wd,
                                   logic [7:0] rx);
            t_spi_beat  r;
            logic [4:0] nh;
            r = '0;
            case (f)
                sewbc_pkg::FN_WRITE: begin
                    if (int'(a) < CACHE_BYTES) begin
                        cache[a] = wd;
                        if (phase == sewbc_pkg::PH_IDLE) begin
                            cur_addr   = a;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = sewbc_pkg::CMD_WREN;
                            phase      = sewbc_pkg::PH_ENABLE;
                        end else begin
                            nh = ring_next(q_head);
                            if (nh == q_tail) begin
                                r.overflow = 1'b1;
                            end else begin
                                pending_addr[nh] = a;
                                q_head           = nh;
                            end
                        end
                    end
                end
                sewbc_pkg::FN_READ: begin
                    if (int'(a) < CACHE_BYTES) r.rd_data = cache[a];
                end
                sewbc_pkg::FN_LOAD: begin
                    if (phase == sewbc_pkg::PH_IDLE) begin
                        load_cnt   = '0;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = sewbc_pkg::CMD_READ;
                        phase      = sewbc_pkg::PH_RD_START;
                    end
                end
                default: begin
                    case (phase)
                        sewbc_pkg::PH_ENABLE: begin
                            r.cs_pulse = 1'b1;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = sewbc_pkg::CMD_WRITE;
                            phase      = sewbc_pkg::PH_CMD;
                        end
                        sewbc_pkg::PH_CMD: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = cur_addr;
                            phase      = sewbc_pkg::PH_ADDRESS;
                        end
                        sewbc_pkg::PH_ADDRESS: begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = (int'(cur_addr) < CACHE_BYTES) ? cache[cur_addr] : 8'd0;
                            phase      = sewbc_pkg::PH_DATA;
                        end
                        sewbc_pkg::PH_DATA: begin
                            r.cs_pulse = 1'b1;
                            r.tx_valid = 1'b1;
                            r.tx_byte  = sewbc_pkg::CMD_RD_STATUS;
                            phase      = sewbc_pkg::PH_STATUS1;
                        end
                        sewbc_pkg::PH_STATUS1: begin
                            r.tx_valid = 1'b1;
                            phase      = sewbc_pkg::PH_STATUS2;
                        end
                        sewbc_pkg::PH_STATUS2: begin
                            r.cs_pulse = 1'b1;
                            r.tx_valid = 1'b1;
                            if (rx[sewbc_pkg::WIP_BIT]) begin
                                r.tx_byte = sewbc_pkg::CMD_RD_STATUS;
                                phase     = sewbc_pkg::PH_STATUS1;
                            end else begin
                                r.tx_byte = sewbc_pkg::CMD_WR_DISABLE;
                                phase     = sewbc_pkg::PH_DISABLE;
                            end
                        end
                        sewbc_pkg::PH_DISABLE: begin
                            if (q_head == q_tail) begin
                                phase = sewbc_pkg::PH_IDLE;
                            end else begin
                                q_tail     = ring_next(q_tail);
                                cur_addr   = pending_addr[q_tail];
                                r.cs_pulse = 1'b1;
                                r.tx_valid = 1'b1;
                                r.tx_byte  = sewbc_pkg::CMD_WREN;
                                phase      = sewbc_pkg::PH_ENABLE;
                            end
                        end
                        sewbc_pkg::PH_RD_START: begin
                            load_cnt   = '0;
                            r.tx_valid = 1'b1;
                            phase      = sewbc_pkg::PH_RD_ADDRESS;
                        end
                        sewbc_pkg::PH_RD_ADDRESS: begin
                            r.tx_valid = 1'b1;
                            phase      = sewbc_pkg::PH_RD_DATA;
                        end
                        sewbc_pkg::PH_RD_DATA: begin
                            if (int'(load_cnt) < CACHE_BYTES) cache[load_cnt[7:0]] = rx;
                            load_cnt = load_cnt + 9'd1;
                            if (int'(load_cnt) < CACHE_BYTES) begin
                                r.tx_valid = 1'b1;
                            end else begin
                                r.load_done = 1'b1;
                                phase       = sewbc_pkg::PH_IDLE;
                            end
                        end
                        default: phase = sewbc_pkg::PH_IDLE;
                    endcase
                end
            endcase
            r.cs_high  = (phase == sewbc_pkg::PH_IDLE);
            r.busy_res = (phase != sewbc_pkg::PH_IDLE);
            expected_beats.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("%s", msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("beat %0d %s: got 0x%0h, want 0x%0h", beat_no, name, got, want));
        endtask

        task check_beat(t_spi_beat got);
            t_spi_beat want;
            beat_no++;
            if (expected_beats.size() == 0) begin
                report($sformatf("beat %0d arrived with no command outstanding", beat_no));
                return;
            end
            want = expected_beats.pop_front();
            compare_field("tx_valid", got.tx_valid, want.tx_valid);
            compare_field("tx_byte", got.tx_byte, want.tx_byte);
            compare_field("cs_pulse", got.cs_pulse, want.cs_pulse);
            compare_field("cs_high", got.cs_high, want.cs_high);
            compare_field("rd_data", got.rd_data, want.rd_data);
            compare_field("load_done", got.load_done, want.load_done);
            compare_field("busy_res", got.busy_res, want.busy_res);
            compare_field("overflow", got.overflow, want.overflow);
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_func;
    logic [7:0] i_addr;
    logic [7:0] i_wr_data;
    logic [7:0] i_rx_byte;
    logic       o_strobe;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_cs_pulse;
    logic       o_cs_high;
    logic [7:0] o_rd_data;
    logic       o_load_done;
    logic       o_busy_res;
    logic       o_overflow;

    t_beat_scoreboard sb;
    int               cycles;
    int               burst_left;

    spi_eeprom_write_back_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_addr      (i_addr),
        .i_wr_data   (i_wr_data),
        .i_rx_byte   (i_rx_byte),
        .o_strobe    (o_strobe),
        .o_tx_valid  (o_tx_valid),
        .o_tx_byte   (o_tx_byte),
        .o_cs_pulse  (o_cs_pulse),
        .o_cs_high   (o_cs_high),
        .o_rd_data   (o_rd_data),
        .o_load_done (o_load_done),
        .o_busy_res  (o_busy_res),
        .o_overflow  (o_overflow)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1)
            sb.check_beat('{o_tx_valid, o_tx_byte, o_cs_pulse, o_cs_high, o_rd_data,
                            o_load_done, o_busy_res, o_overflow});
    end

    // Entered and left at a falling edge; start stays high into the next command.
    task send_command(sewbc_pkg::t_func f, logic [7:0] a, logic [7:0] wd, logic [7:0] rx,
                      int idle_pct);
        bit taken;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start     <= 1'b1;
        i_func    <= f;
        i_addr    <= a;
        i_wr_data <= wd;
        i_rx_byte <= rx;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                sb.note_command(f, a, wd, rx);
            end
            @(negedge i_clk);
        end
    endtask

    task wait_all_results();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task random_command(int idle_pct, output bit counted);
        sewbc_pkg::t_func  f;
        sewbc_pkg::t_phase ph;
        int                r;
        ph = sb.phase;
        r  = $urandom_range(99);
        if (burst_left > 0) begin
            f = sewbc_pkg::FN_WRITE;
            burst_left--;
        end else if (ph != sewbc_pkg::PH_IDLE) begin
            if (r < 72)      f = sewbc_pkg::FN_BYTE;
            else if (r < 87) f = sewbc_pkg::FN_WRITE;
            else if (r < 95) f = sewbc_pkg::FN_READ;
            else if (r < 97) f = sewbc_pkg::FN_LOAD;
            else begin
                f          = sewbc_pkg::FN_WRITE;
                burst_left = $urandom_range(45, 30);
            end
        end else begin
            if (r < 50)      f = sewbc_pkg::FN_WRITE;
            else if (r < 72) f = sewbc_pkg::FN_READ;
            else if (r < 75) f = sewbc_pkg::FN_LOAD;
            else if (r < 88) f = sewbc_pkg::FN_BYTE;
            else begin
                f          = sewbc_pkg::FN_WRITE;
                burst_left = $urandom_range(45, 30);
            end
        end
        counted = !((f == sewbc_pkg::FN_LOAD && ph != sewbc_pkg::PH_IDLE) ||
                    (f == sewbc_pkg::FN_BYTE && ph == sewbc_pkg::PH_IDLE));
        send_command(f, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), idle_pct);
    endtask

    initial begin
        int idle_pct [3];
        int n;
        bit counted;
        sb         = new();
        cycles     = 0;
        burst_left = 0;
        idle_pct   = '{38, 88, 0};
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_func     = sewbc_pkg::FN_READ;
        i_addr     = '0;
        i_wr_data  = '0;
        i_rx_byte  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_command(sewbc_pkg::FN_READ, 8'h00, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_READ, 8'hFF, 8'hFF, 8'hFF, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'hFF, 0);
        send_command(sewbc_pkg::FN_WRITE, 8'hFF, 8'hFF, 8'h00, 0);
        send_command(sewbc_pkg::FN_WRITE, 8'h00, 8'h00, 8'hFF, 0);
        send_command(sewbc_pkg::FN_WRITE, 8'h80, 8'h5A, 8'h00, 0);
        send_command(sewbc_pkg::FN_LOAD, 8'h00, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_READ, 8'hFF, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'hFF, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'hFF, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'h00, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'h01, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'hFF, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'hFE, 0);
        send_command(sewbc_pkg::FN_BYTE, 8'h00, 8'h00, 8'h00, 0);
        wait_all_results();

        foreach (idle_pct[p]) begin
            n = 0;
            while (n < 534) begin
                random_command(idle_pct[p], counted);
                if (counted) n++;
            end
            wait_all_results();
        end

        repeat (8) @(negedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
